// File: sv/msp_pkg.sv
// Package for the multi-axis step/dir pulse generator.
// Shared constants, action codes and per-axis control/status structs.
// No dependencies.
package msp_pkg;

    localparam int AXIS_SLOTS = 4;
    localparam int AXIS_W     = 2;
    localparam int STEPS_W    = 24;   // move_steps field width
    localparam int PERIOD_W   = 20;   // tick_period field width
    localparam int IN_TDATA_W = 48;   // 24 + 20 + 1 bits, padded to bytes
    localparam int IN_TUSER_W = 3;    // action + axis
    localparam int OUT_TDATA_W = 16;  // four 4-bit status fields

    // action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // control from the top level to one axis
    typedef struct packed {
        logic advance;  // item moves from input register to result register
        logic tick;     // item is a timer tick
        logic load;     // item loads this axis
        logic dir;      // direction for a load
    } t_axis_ctl;

    // next-state status from one axis, registered by the top level
    typedef struct packed {
        logic step;
        logic dir;
        logic busy;
        logic done;
    } t_axis_stat;

endpackage

// File: sv/msp_axis.sv
// One stepper axis: step/tick counters, goals, direction and enable.
// Depends on msp_pkg (t_axis_ctl, t_axis_stat).
module msp_axis #(
    parameter int STEP_COUNT_BITS = 24,
    parameter int PERIOD_BITS     = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  msp_pkg::t_axis_ctl         i_ctl,
    input  logic [STEP_COUNT_BITS-1:0] i_steps,
    input  logic [PERIOD_BITS-1:0]     i_period,
    output msp_pkg::t_axis_stat        o_stat
);
    import msp_pkg::*;

    logic [PERIOD_BITS-1:0]     r_tick,   n_tick;
    logic [STEP_COUNT_BITS-1:0] r_done,   n_done;
    logic [STEP_COUNT_BITS-1:0] r_goal,   n_goal;
    logic [PERIOD_BITS-1:0]     r_period, n_period;
    logic                       r_dir,    n_dir;
    logic                       r_on,     n_on;
    logic                       w_step,   w_fin;

    always_comb begin
        n_tick   = r_tick;
        n_done   = r_done;
        n_goal   = r_goal;
        n_period = r_period;
        n_dir    = r_dir;
        n_on     = r_on;
        w_step   = 1'b0;
        w_fin    = 1'b0;
        if (i_ctl.load) begin
            n_goal   = i_steps;
            n_period = i_period;
            n_dir    = i_ctl.dir;
            n_tick   = '0;
            n_done   = '0;
            n_on     = 1'b1;
        end else if (i_ctl.tick && r_on) begin
            if (r_done == r_goal) begin
                // move complete
                n_on     = 1'b0;
                n_tick   = '0;
                n_done   = '0;
                n_goal   = '0;
                n_period = '0;
                w_fin    = 1'b1;
            end else if (r_tick == r_period) begin
                n_tick = '0;
                n_done = r_done + 1'b1;
                w_step = 1'b1;
            end else begin
                n_tick = r_tick + 1'b1;
            end
        end
    end

    assign o_stat.step = w_step;
    assign o_stat.dir  = n_dir;
    assign o_stat.busy = n_on;
    assign o_stat.done = w_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on  <= 1'b0;
            r_dir <= 1'b0;
        end else if (i_ctl.advance) begin
            r_on  <= n_on;
            r_dir <= n_dir;
        end
    end

    // counters and goals only matter while the axis is enabled
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_tick   <= n_tick;
            r_done   <= n_done;
            r_goal   <= n_goal;
            r_period <= n_period;
        end
    end

endmodule

// File: sv/multi_axis_step_pulse_generator.sv
// Top level of the multi-axis step/dir pulse generator.
// Depends on msp_pkg and msp_axis.
//
// Usage:
//  - Slave stream carries commands. tuser selects the action (tick or load)
//    and the target axis; tdata carries the step goal, tick period and
//    direction for a load (ignored on a tick).
//  - A load arms one axis: counters cleared, goals and direction taken,
//    axis enabled. A load into a running axis replaces the move at once.
//    A load to an axis index at or above NUM_AXES changes nothing.
//  - A tick advances every enabled axis: it finishes (done bit) when its
//    step count has reached the goal, else steps when its tick counter
//    equals the period, else counts the tick.
//  - Every command beat yields exactly one status beat on the master
//    stream: step pulses, direction levels, busy and done bits per axis.
// Timing: a beat sits in the input register, where the axis compare/increment
//  logic works on it, then lands in the output register, which drives the
//  status beat; one beat per cycle sustained while the master side does not
//  stall. The input register refills while the output register holds.
// Stall: when the master side stalls, the output register holds its beat
//  and the input register holds one more; tready then drops.
// Reset (i_rst_n low, synchronous): all axes idle, directions clockwise,
//  both pipeline registers empty.
module multi_axis_step_pulse_generator #(
    parameter int NUM_AXES        = 4,
    parameter int STEP_COUNT_BITS = 24,
    parameter int PERIOD_BITS     = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: move_steps[23:0], tick_period[43:24], move_dir[44], zero pad
    input  logic [msp_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: action[0], axis[2:1]
    input  logic [msp_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    // status stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: step_pulses[3:0], dir_levels[7:4], busy_axes[11:8],
    //        done_axes[15:12]
    output logic [msp_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import msp_pkg::*;

    // input register
    logic                       r_in_vld;
    logic                       r_in_act;
    logic [AXIS_W-1:0]          r_in_axis;
    logic [STEP_COUNT_BITS-1:0] r_in_steps;
    logic [PERIOD_BITS-1:0]     r_in_period;
    logic                       r_in_dir;

    // output register
    logic                       r_out_vld;
    logic [AXIS_SLOTS-1:0]      r_step, r_dir, r_busy, r_done;

    logic                       w_advance;
    logic                       w_in_take;
    t_axis_stat                 w_stat [AXIS_SLOTS];
    logic [AXIS_SLOTS-1:0]      w_step, w_dir, w_busy, w_done;

    // input register moves on whenever the output register is free or drains
    assign w_advance       = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_act    <= i_s_axis_tuser[0];
            r_in_axis   <= i_s_axis_tuser[AXIS_W:1];
            r_in_steps  <= STEP_COUNT_BITS'(i_s_axis_tdata[STEPS_W-1:0]);
            r_in_period <= PERIOD_BITS'(i_s_axis_tdata[STEPS_W+PERIOD_W-1:STEPS_W]);
            r_in_dir    <= i_s_axis_tdata[STEPS_W+PERIOD_W];
        end
    end

    // per-axis logic; unused slots read as zero
    for (genvar gi = 0; gi < AXIS_SLOTS; gi++) begin : g_axis
        if (gi < NUM_AXES) begin : g_live
            t_axis_ctl w_ctl;
            assign w_ctl.advance = w_advance;
            assign w_ctl.tick    = (r_in_act == ACT_TICK);
            assign w_ctl.load    = (r_in_act == ACT_LOAD) && (r_in_axis == AXIS_W'(gi));
            assign w_ctl.dir     = r_in_dir;

            msp_axis #(
                .STEP_COUNT_BITS (STEP_COUNT_BITS),
                .PERIOD_BITS     (PERIOD_BITS)
            ) u_axis (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_steps  (r_in_steps),
                .i_period (r_in_period),
                .o_stat   (w_stat[gi])
            );
        end else begin : g_idle
            assign w_stat[gi] = '0;
        end
        assign w_step[gi] = w_stat[gi].step;
        assign w_dir[gi]  = w_stat[gi].dir;
        assign w_busy[gi] = w_stat[gi].busy;
        assign w_done[gi] = w_stat[gi].done;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_step <= w_step;
            r_dir  <= w_dir;
            r_busy <= w_busy;
            r_done <= w_done;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_done, r_busy, r_dir, r_step};

`ifndef ASSERT_OFF
    // an axis never steps and finishes on the same tick
    a_step_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_step & r_done) == '0))
        else $error("axis stepped and finished together");

    // a finished axis is idle; a stepping axis is still enabled
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (((r_done & r_busy) == '0) && ((r_step & ~r_busy) == '0)))
        else $error("busy bit inconsistent with step/done");

    // a load beat reports neither pulses nor completions
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_act == ACT_LOAD)) |=> ((r_step == '0) && (r_done == '0)))
        else $error("load beat produced step or done bits");

    // a load to axis 0 leaves it busy
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_act == ACT_LOAD) && (r_in_axis == AXIS_W'(0)))
            |=> r_busy[0])
        else $error("loaded axis not busy");
`endif

endmodule

// File: tb/sv/multi_axis_step_pulse_generator_checker.sv
`timescale 1ns / 100ps
// Status checker for the multi-axis step/dir pulse generator testbench.
// Predicts each status beat from the command beats; uses msp_pkg for widths and action codes.
module multi_axis_step_pulse_generator_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_valid,
    input  logic                            i_s_ready,
    input  logic [msp_pkg::IN_TDATA_W-1:0]  i_s_data,
    input  logic [msp_pkg::IN_TUSER_W-1:0]  i_s_user,
    input  logic                            i_m_valid,
    input  logic                            i_m_ready,
    input  logic [msp_pkg::OUT_TDATA_W-1:0] i_m_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import msp_pkg::*;

    localparam int NUM_AXES = 4;

    // packed so that step_pulses lands in the low nibble, as on the port
    typedef struct packed {
        logic [3:0] done_axes;
        logic [3:0] busy_axes;
        logic [3:0] dir_levels;
        logic [3:0] step_pulses;
    } t_status;

    logic [PERIOD_W-1:0] tick_ctr      [AXIS_SLOTS];
    logic [STEPS_W-1:0]  steps_taken   [AXIS_SLOTS];
    logic [STEPS_W-1:0]  steps_target  [AXIS_SLOTS];
    logic [PERIOD_W-1:0] period_target [AXIS_SLOTS];
    logic                dir_lvl       [AXIS_SLOTS];
    logic                armed         [AXIS_SLOTS];

    t_status status_due[$];
    t_status want, got;
    int      beat_no;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        beat_no      = 0;
    end

    task automatic report(input string msg);
        $display("status beat %0d: %s", beat_no, msg);
        o_fail_count++;
    endtask

    // next status of all axes after one command beat
    function automatic t_status step_axes(input logic action, input logic [AXIS_W-1:0] sel,
                                          input logic [STEPS_W-1:0] steps,
                                          input logic [PERIOD_W-1:0] period,
                                          input logic dir);
        t_status s;
        s = '0;
        if (action == ACT_LOAD) begin
            if (int'(sel) < NUM_AXES) begin
                steps_target[sel]  = steps;
                period_target[sel] = period;
                dir_lvl[sel]       = dir;
                tick_ctr[sel]      = '0;
                steps_taken[sel]   = '0;
                armed[sel]         = 1'b1;
            end
        end else begin
            for (int i = 0; i < NUM_AXES; i++) begin
                if (armed[i]) begin
                    if (steps_taken[i] == steps_target[i]) begin
                        armed[i]         = 1'b0;
                        tick_ctr[i]      = '0;
                        steps_taken[i]   = '0;
                        steps_target[i]  = '0;
                        period_target[i] = '0;
                        s.done_axes[i]   = 1'b1;
                    end else if (tick_ctr[i] == period_target[i]) begin
                        tick_ctr[i]      = '0;
                        steps_taken[i]   = steps_taken[i] + 1'b1;
                        s.step_pulses[i] = 1'b1;
                    end else begin
                        tick_ctr[i] = tick_ctr[i] + 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            s.dir_levels[i] = dir_lvl[i];
            s.busy_axes[i]  = armed[i];
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXIS_SLOTS; i++) begin
                tick_ctr[i]      = '0;
                steps_taken[i]   = '0;
                steps_target[i]  = '0;
                period_target[i] = '0;
                dir_lvl[i]       = 1'b0;
                armed[i]         = 1'b0;
            end
            status_due.delete();
        end else begin
            if (i_s_valid && i_s_ready) begin
                status_due.push_back(step_axes(i_s_user[0], i_s_user[2:1],
                                               i_s_data[23:0], i_s_data[43:24],
                                               i_s_data[44]));
            end
            if (i_m_valid && i_m_ready) begin
                got = i_m_data;
                if (status_due.size() == 0) begin
                    report($sformatf("unexpected beat %h", got));
                end else begin
                    want = status_due.pop_front();
                    if (got.step_pulses != want.step_pulses)
                        report($sformatf("step_pulses %h, expected %h",
                                         got.step_pulses, want.step_pulses));
                    if (got.dir_levels != want.dir_levels)
                        report($sformatf("dir_levels %h, expected %h",
                                         got.dir_levels, want.dir_levels));
                    if (got.busy_axes != want.busy_axes)
                        report($sformatf("busy_axes %h, expected %h",
                                         got.busy_axes, want.busy_axes));
                    if (got.done_axes != want.done_axes)
                        report($sformatf("done_axes %h, expected %h",
                                         got.done_axes, want.done_axes));
                end
                beat_no++;
            end
        end
        o_pending <= status_due.size();
    end

endmodule

// File: tb/sv/multi_axis_step_pulse_generator_test.sv
`timescale 1ns / 100ps
// Top of the multi-axis step/dir pulse generator testbench: clock, reset, command
// and status stream drivers, watchdog and verdict. Depends on msp_pkg and the checker.
module multi_axis_step_pulse_generator_test;
    import msp_pkg::*;

    localparam int LIMIT      = 2000;  // cycles without any beat before giving up
    localparam int LONG_HOLD  = 400;   // long receiver stall, fills the pipeline
    localparam int RAND_ITEMS = 1950;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // tdata: move_steps[23:0], tick_period[43:24], move_dir[44], zero pad
    logic [IN_TDATA_W-1:0]  s_tdata;
    // tuser: action[0], axis[2:1]
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // tdata: step_pulses[3:0], dir_levels[7:4], busy_axes[11:8], done_axes[15:12]
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int idle_cycles;

    // handshake flags between the command and status processes
    bit hold_req;
    bit calm_tx;
    int rush_left;

    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    multi_axis_step_pulse_generator i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    multi_axis_step_pulse_generator_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_valid    (s_tvalid),
        .i_s_ready    (s_tready),
        .i_s_data     (s_tdata),
        .i_s_user     (s_tuser),
        .i_m_valid    (m_tvalid),
        .i_m_ready    (m_tready),
        .i_m_data     (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // One command beat. Waits its gap with tvalid low, then holds the beat until
    // accepted. tvalid is left high so back-to-back beats never glitch it.
    task automatic send_cmd(input logic action, input logic [AXIS_W-1:0] sel,
                            input logic [STEPS_W-1:0] steps,
                            input logic [PERIOD_W-1:0] period, input logic dir);
        int gap;
        gap = (calm_tx || rush_left > 0) ? 0 : $urandom_range(0, 16);
        if (rush_left > 0)
            rush_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {3'b000, dir, period, steps};
        s_tuser  <= {sel, action};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!(s_tvalid && s_tready))
            @(posedge clk);
    endtask

    // drop tvalid and wait until every status beat has come back
    task automatic drain_status();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_random_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            if ($urandom_range(0, 4) == 0)
                // full range: reaches every bit of the goal and period fields
                send_cmd(ACT_LOAD, AXIS_W'($urandom), STEPS_W'($urandom),
                         PERIOD_W'($urandom), 1'($urandom));
            else
                // short moves so that axes run to completion often
                send_cmd(ACT_LOAD, AXIS_W'($urandom), STEPS_W'($urandom_range(0, 6)),
                         PERIOD_W'($urandom_range(0, 4)), 1'($urandom));
        end else begin
            // tick: axis and data bits are don't-care, drive them random
            send_cmd(ACT_TICK, AXIS_W'($urandom), STEPS_W'($urandom),
                     PERIOD_W'($urandom), 1'($urandom));
        end
    endtask

    // status side: random stall per beat, calm stretches, one long hold-off
    initial begin
        int gap;
        int beats;
        bit calm_rx;
        m_tready = 1'b0;
        beats    = 0;
        calm_rx  = 1'b0;
        forever begin
            if (beats % 50 == 0)
                calm_rx = ($urandom_range(0, 3) == 0);
            gap = calm_rx ? 0 : $urandom_range(0, 16);
            if (hold_req) begin
                gap      = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
            beats++;
        end
    end

    // watchdog: any beat on either side restarts the count
    initial begin
        idle_cycles = 0;
        while (idle_cycles < LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[multi_axis_step_pulse_generator] ERROR");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        hold_req  = 1'b0;
        calm_tx   = 1'b0;
        rush_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // tick with every axis idle, don't-care fields all ones
        send_cmd(ACT_TICK, 2'b11, '1, '1, 1'b1);
        // zero step goal: finishes on the first tick
        send_cmd(ACT_LOAD, 2'd0, '0, '0, 1'b0);
        send_cmd(ACT_TICK, 2'd0, '0, '0, 1'b0);
        // period zero: one step per tick, then done
        send_cmd(ACT_LOAD, 2'd1, 24'd2, 20'd0, 1'b1);
        send_cmd(ACT_TICK, 2'd0, '0, '0, 1'b0);
        send_cmd(ACT_TICK, 2'd0, '0, '0, 1'b0);
        send_cmd(ACT_TICK, 2'd0, '0, '0, 1'b0);
        // largest goal and period, counter-clockwise; stays busy
        send_cmd(ACT_LOAD, 2'd2, '1, '1, 1'b1);
        // period two on axis 3: count, count, step, done
        send_cmd(ACT_LOAD, 2'd3, 24'd1, 20'd2, 1'b0);
        send_cmd(ACT_TICK, 2'd3, '0, '0, 1'b0);
        send_cmd(ACT_TICK, 2'd3, '0, '0, 1'b0);
        send_cmd(ACT_TICK, 2'd3, '0, '0, 1'b0);
        send_cmd(ACT_TICK, 2'd3, '0, '0, 1'b0);
        // reload the busy axis 2: replaced at once, no done bit
        send_cmd(ACT_LOAD, 2'd2, 24'd1, 20'd0, 1'b0);
        send_cmd(ACT_TICK, 2'd1, '0, '0, 1'b0);
        send_cmd(ACT_TICK, 2'd1, '0, '0, 1'b0);
        // all four axes running together
        send_cmd(ACT_LOAD, 2'd0, 24'd3, 20'd1, 1'b1);
        send_cmd(ACT_LOAD, 2'd1, 24'd2, 20'd0, 1'b0);
        send_cmd(ACT_LOAD, 2'd2, 24'd1, 20'd2, 1'b1);
        send_cmd(ACT_LOAD, 2'd3, 24'd0, 20'd0, 1'b1);
        repeat (5) send_cmd(ACT_TICK, 2'd2, '0, '0, 1'b0);

        // --- random part ---
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 64 == 0)
                calm_tx = ($urandom_range(0, 3) == 0);
            if (n == 600) begin
                // receiver stalls long while commands keep coming back to back
                hold_req  = 1'b1;
                rush_left = 40;
            end
            if (n == 1300)
                drain_status();
            send_random_cmd();
        end

        drain_status();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[multi_axis_step_pulse_generator] OK");
        else
            $display("[multi_axis_step_pulse_generator] ERROR");
        $finish;
    end

endmodule
